### design/urk_pkg.sv
// Shared constants, register codes and divider handshake types for the range filter.
`default_nettype none

package urk_pkg;

	localparam int NUM_SENSORS = 4;
	localparam int SENSOR_W    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	localparam int REM_W = 34;
	localparam int QUO_W = 32;
	localparam int CNT_W = 6;

	localparam logic [CNT_W-1:0] DISP_STEPS = 6'd27;
	localparam logic [CNT_W-1:0] GAIN_STEPS = 6'd17;

	localparam logic [26:0] Z_RECIP = 27'd85899346;

	localparam logic [31:0] PROC_NOISE_RST = 32'd655;
	localparam logic [31:0] MEAS_NOISE_RST = 32'd65536;
	localparam logic [31:0] INIT_VAR_RST   = 32'd65536;
	localparam logic [31:0] INIT_RANGE_RST = 32'd0;

	typedef enum logic [2:0] {
		REG_PROC_NOISE = 3'd0,
		REG_MEAS_NOISE = 3'd1,
		REG_COS_PACK   = 3'd2,
		REG_SIN_PACK   = 3'd3,
		REG_INIT_VAR   = 3'd4,
		REG_INIT_RANGE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
		logic [REM_W-1:0] init_rem;
		logic [QUO_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### design/ultrasonic_range_kalman_unit.sv
// Per-sensor scalar Kalman range filter: top level with sequencer and state.
//
// Input channel (in_valid/in_ready) takes one word per reading: sensor_index,
// range_cm, vel_x, vel_y, rate_hz. Output channel (out_valid/out_ready) gives
// one word per reading: out_sensor, estimate, prior_estimate, variance.
// Configuration is a write-only port (cfg_wr_en, cfg_index, cfg_data); the user
// must use it only while the unit is idle, which the unit does not enforce;
// writing the starting variance or range loads every sensor's state at once.
// The shared bit-serial divider runs 27 steps for the motion term and 17 steps
// for the gain.
// in_ready is high only while the sequencer is idle; a finished word sits in
// the output register, so the next reading may be accepted while it waits.
// If out_ready stays low, the next result is held in its final step until
// the output register frees up.
// Reset clears the sequencer and output valid, sets registers to their
// defaults and loads every sensor's estimate and variance.
`default_nettype none

module ultrasonic_range_kalman_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [2:0]                       cfg_index,
	input  wire logic [63:0]                      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       sensor_index,
	input  wire logic [9:0]                       range_cm,
	input  wire logic signed [15:0]               vel_x,
	input  wire logic signed [15:0]               vel_y,
	input  wire logic [7:0]                       rate_hz,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [1:0]                            out_sensor,
	output logic signed [31:0]                    estimate,
	output logic signed [31:0]                    prior_estimate,
	output logic [31:0]                           variance
);
	import urk_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MULX   = 10'b0000000010,
		ST_MULY   = 10'b0000000100,
		ST_DSTART = 10'b0000001000,
		ST_DWAIT  = 10'b0000010000,
		ST_KSTART = 10'b0000100000,
		ST_KWAIT  = 10'b0001000000,
		ST_MULK   = 10'b0010000000,
		ST_MULP   = 10'b0100000000,
		ST_UPDATE = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [31:0] qn_q;
	logic [31:0] rn_q;
	logic [63:0] cos_pack_q;
	logic [63:0] sin_pack_q;

	logic [31:0] est_mem_q [NUM_SENSORS];
	logic [31:0] var_mem_q [NUM_SENSORS];

	logic [SENSOR_W-1:0] s_q;
	logic [9:0]          rcm_q;
	logic signed [15:0]  vx_q;
	logic signed [15:0]  vy_q;
	logic [7:0]          rate_q;
	logic signed [15:0]  cos_q;
	logic signed [15:0]  sin_q;
	logic signed [31:0]  prior_q;
	logic [31:0]         var_q;

	logic signed [31:0] px_q;
	logic [52:0]        zp_q;
	logic signed [32:0] v_q;
	logic [32:0]        pp_q;
	logic signed [27:0] disp_q;
	logic signed [33:0] pe_q;
	logic               den_zero_q;
	logic [16:0]        k_q;
	logic signed [34:0] innov_q;
	logic signed [52:0] kp_q;
	logic [49:0]        pv_q;
	logic signed [36:0] corr_q;

	logic               out_valid_q;
	logic [1:0]         out_sensor_q;
	logic signed [31:0] est_out_q;
	logic signed [31:0] prior_out_q;
	logic [31:0]        var_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               in_fire;
	logic               sensor_ok;
	logic               upd_fire;
	logic [5:0]         lane_off;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic [25:0]        zx;
	logic [32:0]        v_abs;
	logic [31:0]        disp_num;
	logic [27:0]        disp_mag;
	logic [33:0]        den;
	logic [49:0]        gain_num;
	logic [19:0]        z;
	logic [52:0]        kp_abs;
	logic [52:0]        kp_rnd;
	logic [36:0]        corr_mag;
	logic signed [37:0] est_w;
	logic [31:0]        est_sat;
	logic [50:0]        pv_rnd;
	logic [34:0]        pnew;
	logic [31:0]        pnew_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign sensor_ok = ({1'b0, sensor_index} < 3'(NUM_SENSORS));
	assign upd_fire  = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	assign lane_off  = {sensor_index, 4'b0000};

	assign px = 32'(vx_q) * 32'(cos_q);
	assign py = 32'(vy_q) * 32'(sin_q);
	assign zx = {rcm_q, 16'b0} + 26'd50;
	assign z  = zp_q[52:33];

	assign v_abs    = v_q[32] ? 33'(-v_q) : v_q;
	assign disp_num = v_abs[31:0] + {19'b0, rate_q, 5'b0};
	assign disp_mag = {2'b00, div_rsp.quotient[25:0]};

	assign den      = {1'b0, pp_q} + {2'b00, rn_q};
	assign gain_num = {1'b0, pp_q, 16'b0} + {17'b0, den[33:1]};

	assign kp_abs   = kp_q[52] ? 53'(-kp_q) : kp_q;
	assign kp_rnd   = kp_abs + 53'd32768;
	assign corr_mag = kp_rnd[52:16];

	assign est_w   = 38'(pe_q) + 38'(corr_q);
	assign est_sat = (est_w[37:31] == {7{est_w[37]}}) ? est_w[31:0]
		: (est_w[37] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	assign pv_rnd   = {1'b0, pv_q} + 51'd32768;
	assign pnew     = pv_rnd[50:16];
	assign pnew_sat = (|pnew[34:32]) ? 32'hFFFF_FFFF : pnew[31:0];

	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_DSTART: begin
				div_req.start    = 1'b1;
				div_req.steps    = DISP_STEPS;
				div_req.init_rem = {29'b0, disp_num[31:27]};
				div_req.dividend = {disp_num[26:0], 5'b0};
				div_req.divisor  = {20'b0, rate_q, 6'b0};
			end
			ST_KSTART: begin
				div_req.start    = 1'b1;
				div_req.steps    = GAIN_STEPS;
				div_req.init_rem = {1'b0, gain_num[49:17]};
				div_req.dividend = {gain_num[16:0], 15'b0};
				div_req.divisor  = den;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	urk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && sensor_ok) state_q <= ST_MULX;
				end
				ST_MULX:   state_q <= ST_MULY;
				ST_MULY:   state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_rsp.done) state_q <= ST_KSTART;
				end
				ST_KSTART: state_q <= ST_KWAIT;
				ST_KWAIT: begin
					if (div_rsp.done) state_q <= ST_MULK;
				end
				ST_MULK:   state_q <= ST_MULP;
				ST_MULP:   state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (upd_fire) state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s_q     <= sensor_index[SENSOR_W-1:0];
			rcm_q   <= range_cm;
			vx_q    <= vel_x;
			vy_q    <= vel_y;
			rate_q  <= rate_hz;
			cos_q   <= cos_pack_q[lane_off +: 16];
			sin_q   <= sin_pack_q[lane_off +: 16];
			prior_q <= est_mem_q[sensor_index[SENSOR_W-1:0]];
			var_q   <= var_mem_q[sensor_index[SENSOR_W-1:0]];
		end
		if (state_q == ST_MULX) begin
			px_q <= px;
			zp_q <= 53'(zx) * 53'(Z_RECIP);
		end
		if (state_q == ST_MULY) begin
			v_q  <= 33'(px_q) + 33'(py);
			pp_q <= {1'b0, var_q} + {1'b0, qn_q};
		end
		if (state_q == ST_DWAIT && div_rsp.done) begin
			if (rate_q == 8'd0) begin
				disp_q <= '0;
			end else begin
				disp_q <= v_q[32] ? -$signed(disp_mag) : $signed(disp_mag);
			end
		end
		if (state_q == ST_KSTART) begin
			pe_q       <= 34'(prior_q) - 34'(disp_q);
			den_zero_q <= (den == 34'd0);
		end
		if (state_q == ST_KWAIT && div_rsp.done) begin
			k_q     <= den_zero_q ? 17'd0 : div_rsp.quotient[16:0];
			innov_q <= $signed({15'b0, z}) - 35'(pe_q);
		end
		if (state_q == ST_MULK) begin
			kp_q <= 53'($signed({1'b0, k_q})) * 53'(innov_q);
		end
		if (state_q == ST_MULP) begin
			pv_q   <= 50'({1'b1, 16'b0} - k_q) * 50'(pp_q);
			corr_q <= kp_q[52] ? -$signed(corr_mag) : $signed(corr_mag);
		end
		if (upd_fire) begin
			out_sensor_q <= 2'(s_q);
			est_out_q    <= est_sat;
			prior_out_q  <= prior_q;
			var_out_q    <= pnew_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q       <= PROC_NOISE_RST;
			rn_q       <= MEAS_NOISE_RST;
			cos_pack_q <= '0;
			sin_pack_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PROC_NOISE: qn_q       <= cfg_data[31:0];
				REG_MEAS_NOISE: rn_q       <= cfg_data[31:0];
				REG_COS_PACK:   cos_pack_q <= cfg_data;
				REG_SIN_PACK:   sin_pack_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				est_mem_q[i] <= INIT_RANGE_RST;
				var_mem_q[i] <= INIT_VAR_RST;
			end
		end else if (cfg_wr_en && cfg_index == REG_INIT_VAR) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				var_mem_q[i] <= cfg_data[31:0];
			end
		end else if (cfg_wr_en && cfg_index == REG_INIT_RANGE) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				est_mem_q[i] <= cfg_data[31:0];
			end
		end else if (upd_fire) begin
			est_mem_q[s_q] <= est_sat;
			var_mem_q[s_q] <= pnew_sat;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_sensor     = out_sensor_q;
	assign estimate       = est_out_q;
	assign prior_estimate = prior_out_q;
	assign variance       = var_out_q;

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DWAIT || state_q == ST_KWAIT))
		else $error("divider finished outside a wait step");

	a_gain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULK) |-> (k_q <= 17'd65536))
		else $error("gain above one");

	a_update_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> (out_valid && state_q == ST_IDLE))
		else $error("update did not present a word");
`endif

endmodule

`default_nettype wire

### design/urk_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by both filter divisions.
`default_nettype none

module urk_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire urk_pkg::div_req_t req,
	output urk_pkg::div_rsp_t     rsp
);
	import urk_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsr_q;
	logic [QUO_W-1:0] sh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           ge;

	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.init_rem;
			sh_q  <= req.dividend;
			dsr_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ultrasonic range Kalman unit: directed and random readings.
module tb_top;
	import urk_pkg::*;

	typedef longint          s64_t;
	typedef longint unsigned u64_t;

	typedef struct {
		logic [1:0]         sensor;
		logic [9:0]         range_cm;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [7:0]         rate_hz;
	} reading_t;

	typedef struct {
		logic [1:0]         sensor;
		logic signed [31:0] estimate;
		logic signed [31:0] prior;
		logic [31:0]        variance;
	} range_fix_t;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	class kalman_tracker;
		logic [31:0] proc_noise;
		logic [31:0] meas_noise;
		logic [63:0] cos_pack;
		logic [63:0] sin_pack;
		logic [31:0] init_var;
		logic [31:0] init_range;
		logic [31:0] est_q [NUM_SENSORS];
		logic [31:0] var_q [NUM_SENSORS];
		logic [9:0]  last_cm [NUM_SENSORS];
		range_fix_t  expected_fixes [$];
		int          failures;

		function new();
			proc_noise = PROC_NOISE_RST;
			meas_noise = MEAS_NOISE_RST;
			cos_pack   = '0;
			sin_pack   = '0;
			init_var   = INIT_VAR_RST;
			init_range = INIT_RANGE_RST;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				est_q[i]   = INIT_RANGE_RST;
				var_q[i]   = INIT_VAR_RST;
				last_cm[i] = '0;
			end
			failures = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] data);
			case (idx)
			REG_PROC_NOISE: proc_noise = data[31:0];
			REG_MEAS_NOISE: meas_noise = data[31:0];
			REG_COS_PACK:   cos_pack = data;
			REG_SIN_PACK:   sin_pack = data;
			REG_INIT_VAR: begin
				init_var = data[31:0];
				for (int i = 0; i < NUM_SENSORS; i++) var_q[i] = init_var;
			end
			REG_INIT_RANGE: begin
				init_range = data[31:0];
				for (int i = 0; i < NUM_SENSORS; i++) est_q[i] = init_range;
			end
			default: ;
			endcase
		endfunction

		static function s64_t round_div(s64_t n, u64_t d);
			u64_t mag;
			u64_t q;
			mag = (n < 0) ? u64_t'(-n) : u64_t'(n);
			q = (mag + d / 2) / d;
			return (n < 0) ? -s64_t'(q) : s64_t'(q);
		endfunction

		function void note_reading(reading_t r);
			logic signed [15:0] cos_w;
			logic signed [15:0] sin_w;
			s64_t       proj, shift, prior, pred, z, innov, fix, gain;
			u64_t       pp, den, pnew;
			int         s;
			range_fix_t want;
			s = r.sensor;
			cos_w = cos_pack[16*s +: 16];
			sin_w = sin_pack[16*s +: 16];
			proj = s64_t'(r.vel_x) * s64_t'(cos_w) + s64_t'(r.vel_y) * s64_t'(sin_w);
			shift = (r.rate_hz == 0) ? 0 : round_div(proj, u64_t'(r.rate_hz) * 64);
			prior = s64_t'($signed(est_q[s]));
			pred = prior - shift;
			pp = u64_t'(var_q[s]) + u64_t'(proc_noise);
			den = pp + u64_t'(meas_noise);
			gain = (den == 0) ? 0 : s64_t'((pp * 65536 + den / 2) / den);
			z = s64_t'((u64_t'(r.range_cm) * 65536 + 50) / 100);
			innov = z - pred;
			fix = pred + round_div(gain * innov, 65536);
			if (fix > 64'sd2147483647) fix = 64'sd2147483647;
			else if (fix < -64'sd2147483648) fix = -64'sd2147483648;
			pnew = (u64_t'(65536 - gain) * pp + 32768) >> 16;
			if (pnew > 64'hFFFF_FFFF) pnew = 64'hFFFF_FFFF;
			want.sensor = r.sensor;
			want.prior  = est_q[s];
			last_cm[s] = r.range_cm;
			est_q[s]   = fix[31:0];
			var_q[s]   = pnew[31:0];
			want.estimate = est_q[s];
			want.variance = var_q[s];
			expected_fixes.push_back(want);
		endfunction

		function void check_result(range_fix_t got);
			range_fix_t want;
			if (expected_fixes.size() == 0) begin
				$error("out_sensor %0d: word with no reading pending", got.sensor);
				failures++;
				return;
			end
			want = expected_fixes.pop_front();
			if (got.sensor !== want.sensor) begin
				$error("out_sensor: expected %0d, actual %0d", want.sensor, got.sensor);
				failures++;
			end
			if (got.estimate !== want.estimate) begin
				$error("estimate: expected %0d, actual %0d", want.estimate, got.estimate);
				failures++;
			end
			if (got.prior !== want.prior) begin
				$error("prior_estimate: expected %0d, actual %0d", want.prior, got.prior);
				failures++;
			end
			if (got.variance !== want.variance) begin
				$error("variance: expected %0d, actual %0d", want.variance, got.variance);
				failures++;
			end
		endfunction

		function int pending();
			return expected_fixes.size();
		endfunction

		function void finish_check();
			if (expected_fixes.size() != 0) begin
				$error("%0d result words never arrived", expected_fixes.size());
				failures++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         sensor_index = '0;
	logic [9:0]         range_cm = '0;
	logic signed [15:0] vel_x = '0;
	logic signed [15:0] vel_y = '0;
	logic [7:0]         rate_hz = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         out_sensor;
	logic signed [31:0] estimate;
	logic signed [31:0] prior_estimate;
	logic [31:0]        variance;

	int unsigned   send_idle_pct = 0;
	int unsigned   stall_pct = 0;
	reading_t      last_pick = '{2'd0, 10'd300, 16'sd0, 16'sd0, 8'd20};
	kalman_tracker tracker = new();

	ultrasonic_range_kalman_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sensor_index(sensor_index),
		.range_cm(range_cm),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.rate_hz(rate_hz),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_sensor(out_sensor),
		.estimate(estimate),
		.prior_estimate(prior_estimate),
		.variance(variance)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			tracker.note_reading('{sensor_index, range_cm, vel_x, vel_y, rate_hz});
		end
		if (arst_n && out_valid && out_ready) begin
			tracker.check_result('{out_sensor, estimate, prior_estimate, variance});
		end
	end

	task automatic put_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		tracker.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_reading(input reading_t r);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 12) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sensor_index <= r.sensor;
		range_cm     <= r.range_cm;
		vel_x        <= r.vel_x;
		vel_y        <= r.vel_y;
		rate_hz      <= r.rate_hz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word(input logic [31:0] typ);
		case ($urandom_range(0, 5))
		0: return 32'd0;
		1: return 32'hFFFF_FFFF;
		2, 3: return $urandom_range(0, typ);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_pack();
		logic [63:0] p;
		case ($urandom_range(0, 5))
		0: p = '0;
		1: p = '1;
		default: begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				case ($urandom_range(0, 4))
				0: p[16*i +: 16] = 16'h4000;
				1: p[16*i +: 16] = 16'hC000;
				2: p[16*i +: 16] = 16'h7FFF;
				3: p[16*i +: 16] = 16'h8000;
				default: p[16*i +: 16] = 16'($urandom);
				endcase
			end
		end
		endcase
		return p;
	endfunction

	function automatic reading_t pick_reading();
		reading_t r;
		if ($urandom_range(0, 1)) begin
			r.sensor   = last_pick.sensor;
			r.range_cm = last_pick.range_cm + 10'($urandom_range(0, 6)) - 10'd3;
		end else begin
			r.sensor = 2'($urandom);
			case ($urandom_range(0, 4))
			0: r.range_cm = '0;
			1: r.range_cm = '1;
			default: r.range_cm = 10'($urandom);
			endcase
		end
		if ($urandom_range(0, 3) == 0) begin
			r.vel_x = 16'($urandom);
			r.vel_y = 16'($urandom);
		end else begin
			r.vel_x = 16'($urandom_range(0, 1024)) - 16'd512;
			r.vel_y = 16'($urandom_range(0, 1024)) - 16'd512;
		end
		case ($urandom_range(0, 9))
		0: r.rate_hz = 8'd0;
		1: r.rate_hz = 8'd255;
		2: r.rate_hz = 8'd1;
		3: r.rate_hz = 8'($urandom);
		default: r.rate_hz = 8'($urandom_range(5, 60));
		endcase
		last_pick = r;
		return r;
	endfunction

	task automatic apply_random_settings();
		wait_quiet();
		put_reg(REG_PROC_NOISE, {32'd0, pick_word(32'd1 << 18)});
		put_reg(REG_MEAS_NOISE, {32'd0, pick_word(32'd1 << 21)});
		put_reg(REG_COS_PACK, pick_pack());
		put_reg(REG_SIN_PACK, pick_pack());
		if ($urandom_range(0, 1)) put_reg(REG_INIT_VAR, {32'd0, pick_word(32'd1 << 20)});
		if ($urandom_range(0, 1)) put_reg(REG_INIT_RANGE, {32'd0, pick_word(32'd20 << 16)});
		if ($urandom_range(0, 3) == 0) begin
			put_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
		end
		end_writes();
	endtask

	initial begin
		int unsigned mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_reg(REG_PROC_NOISE, 64'd655);
		put_reg(REG_MEAS_NOISE, 64'd16384);
		put_reg(REG_COS_PACK, 64'h1234_7FFF_8000_4000);
		put_reg(REG_SIN_PACK, 64'hC000_8000_7FFF_0000);
		put_reg(REG_INIT_VAR, 64'h0001_0000);
		put_reg(REG_INIT_RANGE, 64'h0002_0000);
		end_writes();
		for (int s = 0; s < NUM_SENSORS; s++) begin
			send_reading('{2'(s), 10'd0, 16'sh8000, 16'sh7FFF, 8'd1});
			send_reading('{2'(s), 10'd1023, 16'sh7FFF, 16'sh8000, 8'd255});
			send_reading('{2'(s), 10'd512, 16'sh1234, -16'sd5, 8'd0});
		end

		wait_quiet();
		put_reg(REG_PROC_NOISE, 64'd0);
		put_reg(REG_MEAS_NOISE, 64'd0);
		put_reg(REG_INIT_VAR, 64'd0);
		put_reg(REG_INIT_RANGE, 64'h7FFF_FFFF);
		end_writes();
		send_reading('{2'd0, 10'd100, 16'sh8000, 16'sd0, 8'd1});
		send_reading('{2'd2, 10'd100, 16'sh7FFF, 16'sd0, 8'd1});
		wait_quiet();
		put_reg(REG_INIT_RANGE, 64'h8000_0000);
		end_writes();
		send_reading('{2'd1, 10'd0, 16'sh8000, 16'sd0, 8'd1});
		send_reading('{2'd3, 10'd1023, 16'sh7FFF, 16'sh7FFF, 8'd2});

		wait_quiet();
		put_reg(REG_PROC_NOISE, 64'hFFFF_FFFF);
		put_reg(REG_MEAS_NOISE, 64'hFFFF_FFFF);
		put_reg(REG_COS_PACK, '1);
		put_reg(REG_SIN_PACK, '1);
		put_reg(REG_INIT_VAR, 64'hFFFF_FFFF);
		put_reg(REG_SPARE_LO, '1);
		put_reg(REG_SPARE_HI, 64'h0123_4567_89AB_CDEF);
		end_writes();
		for (int s = 0; s < NUM_SENSORS; s++) begin
			send_reading('{2'(s), 10'(s * 300), 16'sh7FFF, 16'sh8000, 8'd255});
		end

		for (int p = 0; p < 8; p++) begin
			mode = p % 4;
			apply_random_settings();
			send_idle_pct = (mode == 1) ? 64 : (mode == 3) ? 17 : 0;
			stall_pct     = (mode == 2) ? 64 : (mode == 3) ? 17 : 0;
			for (int n = 0; n < 222; n++) begin
				send_reading(pick_reading());
				if ($urandom_range(0, 39) == 0) wait_quiet();
			end
		end

		wait_quiet();
		repeat (60) @(posedge clk);
		tracker.finish_check();
		if (tracker.failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

### files.f
design/urk_pkg.sv
design/urk_div.sv
design/ultrasonic_range_kalman_unit.sv
test/tb_top.sv
